[rtl/core/dual_stepper_half_step_driver_unit_macros.svh]
// Assertion helpers shared by the driver RTL.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef DUAL_STEPPER_HALF_STEP_DRIVER_UNIT_MACROS_SVH
`define DUAL_STEPPER_HALF_STEP_DRIVER_UNIT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define DSD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent holds in the cycle after the antecedent.
`define DSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[rtl/core/dsd_pkg.sv]
package dsd_pkg;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_FORWARD  = 3'd1,
    OP_BACKWARD = 3'd2,
    OP_LEFT     = 3'd3,
    OP_RIGHT    = 3'd4,
    OP_PEN_UP   = 3'd5,
    OP_PEN_DOWN = 3'd6,
    OP_END      = 3'd7
  } op_e;

  localparam int unsigned StepW  = 15;
  localparam int unsigned WidthW = 15;
  localparam int unsigned CoilW  = 4;

  localparam logic [WidthW-1:0] PEN_UP_RESET   = 15'd700;
  localparam logic [WidthW-1:0] PEN_DOWN_RESET = 15'd1200;

  // Register select, taken from paddr[2].
  localparam logic REG_PEN_UP   = 1'b0;
  localparam logic REG_PEN_DOWN = 1'b1;

  // Coil bit touched by each new phase, moving up or down the sequence.
  localparam logic [1:0] UP_BIT [8]   = '{2'd0, 2'd3, 2'd1, 2'd0, 2'd2, 2'd1, 2'd3, 2'd2};
  localparam logic [1:0] DOWN_BIT [8] = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd1, 2'd3, 2'd2, 2'd0};

  typedef struct packed {
    logic step;
    logic add;
    logic neg;
  } wheel_cmd_t;

endpackage

[rtl/core/dsd_wheel.sv]
`include "dual_stepper_half_step_driver_unit_macros.svh"

module dsd_wheel
  import dsd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wheel_cmd_t       cmd_i,
  input  logic [StepW-1:0] count_i,
  output logic [CoilW-1:0] drive_d_o,
  output logic             busy_d_o
);

  localparam int unsigned SumW = ((COUNT_BITS > StepW) ? COUNT_BITS : StepW) + 2;
  localparam logic signed [SumW-1:0] SatHi =
    {{(SumW-COUNT_BITS+1){1'b0}}, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [SumW-1:0] SatLo =
    {{(SumW-COUNT_BITS+1){1'b1}}, {(COUNT_BITS-1){1'b0}}};

  logic signed [COUNT_BITS-1:0] pending_q, pending_d;
  logic [2:0]                   phase_q, phase_d;
  logic [CoilW-1:0]             drive_q, drive_d;
  logic signed [SumW-1:0]       ext_p, ext_n, sum;
  logic [1:0]                   bit_sel;

  always_comb begin
    ext_p = {{(SumW-COUNT_BITS){pending_q[COUNT_BITS-1]}}, pending_q};
    ext_n = {{(SumW-StepW){1'b0}}, count_i};
    sum   = cmd_i.neg ? (ext_p - ext_n) : (ext_p + ext_n);

    pending_d = pending_q;
    phase_d   = phase_q;
    drive_d   = drive_q;
    bit_sel   = 2'd0;

    if (cmd_i.add) begin
      if (sum > SatHi) begin
        pending_d = SatHi[COUNT_BITS-1:0];
      end else if (sum < SatLo) begin
        pending_d = SatLo[COUNT_BITS-1:0];
      end else begin
        pending_d = sum[COUNT_BITS-1:0];
      end
    end else if (cmd_i.step && (pending_q != '0)) begin
      if (!pending_q[COUNT_BITS-1]) begin
        phase_d   = phase_q + 3'd1;
        pending_d = pending_q - 1'b1;
        bit_sel   = UP_BIT[phase_d];
      end else begin
        phase_d   = phase_q - 3'd1;
        pending_d = pending_q + 1'b1;
        bit_sel   = DOWN_BIT[phase_d];
      end
      // Even phases energize a coil, odd phases release one.
      drive_d[bit_sel] = ~phase_d[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      phase_q   <= '0;
      drive_q   <= '0;
    end else begin
      pending_q <= pending_d;
      phase_q   <= phase_d;
      drive_q   <= drive_d;
    end
  end

  assign drive_d_o = drive_d;
  assign busy_d_o  = (pending_d != '0);

  `DSD_ASSERT_SAME(a_step_or_add, cmd_i.step, !cmd_i.add)
  `DSD_ASSERT_NEXT(a_phase_only_on_step, !cmd_i.step, $stable(phase_q) && $stable(drive_q))
  `DSD_ASSERT_NEXT(a_idle_wheel_holds, cmd_i.step && (pending_q == '0), $stable(phase_q))

endmodule

[rtl/core/dual_stepper_half_step_driver_unit.sv]
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+--------------------------------------
// in       | input     | in_valid_i / in_ready_o   | operation_i, step_count_i
// out      | output    | out_valid_o / out_ready_i | left_coils_o, right_coils_o,
//          |           |                           | pen_width_o, busy_res_o, halted_o
// config   | input     | APB psel/penable/pready   | paddr, pwdata, prdata
//
// A request waits in the input register and is executed as it moves into the result register.
// One request per cycle is sustained while out_ready_i is high; the state update is a single
// add/compare per wheel. When out_ready_i is low the result register holds and the input
// register fills, after which in_ready_o drops.
// Reset clears both wheel counters, phases and coils and sets the pen widths to defaults.
`include "dual_stepper_half_step_driver_unit_macros.svh"

module dual_stepper_half_step_driver_unit
  import dsd_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        operation_i,
  input  logic [StepW-1:0]  step_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CoilW-1:0]  left_coils_o,
  output logic [CoilW-1:0]  right_coils_o,
  output logic [WidthW-1:0] pen_width_o,
  output logic              busy_res_o,
  output logic              halted_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic              s1_valid_q;
  op_e               s1_op_q;
  logic [StepW-1:0]  s1_count_q;
  logic              advance, exec;

  logic [WidthW-1:0] up_width_q, down_width_q;
  logic [WidthW-1:0] pen_q, pen_d;
  logic              stopped_q, stopped_d;

  logic              out_valid_q;
  logic [CoilW-1:0]  left_q, right_q;
  logic [WidthW-1:0] pen_out_q;
  logic              busy_q, halted_q;

  wheel_cmd_t        left_cmd, right_cmd;
  logic [CoilW-1:0]  left_drive_d, right_drive_d;
  logic              left_busy_d, right_busy_d;
  logic              cfg_write;

  assign advance    = !out_valid_q || out_ready_i;
  assign exec       = s1_valid_q && advance;
  assign in_ready_o = !s1_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_op_q    <= op_e'(operation_i);
      s1_count_q <= step_count_i;
    end
  end

  // Command decode.
  always_comb begin
    left_cmd  = '0;
    right_cmd = '0;
    pen_d     = pen_q;
    stopped_d = stopped_q;
    if (exec && !stopped_q) begin
      unique case (s1_op_q)
        OP_TICK: begin
          left_cmd.step  = 1'b1;
          right_cmd.step = 1'b1;
        end
        OP_FORWARD: begin
          left_cmd.add  = 1'b1;
          right_cmd.add = 1'b1;
        end
        OP_BACKWARD: begin
          left_cmd  = '{step: 1'b0, add: 1'b1, neg: 1'b1};
          right_cmd = '{step: 1'b0, add: 1'b1, neg: 1'b1};
        end
        OP_LEFT: begin
          left_cmd      = '{step: 1'b0, add: 1'b1, neg: 1'b1};
          right_cmd.add = 1'b1;
        end
        OP_RIGHT: begin
          left_cmd.add = 1'b1;
          right_cmd    = '{step: 1'b0, add: 1'b1, neg: 1'b1};
        end
        OP_PEN_UP:   pen_d = up_width_q;
        OP_PEN_DOWN: pen_d = down_width_q;
        OP_END: begin
          pen_d     = up_width_q;
          stopped_d = 1'b1;
        end
      endcase
    end
  end

  dsd_wheel #(
    .COUNT_BITS(COUNT_BITS)
  ) u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (left_cmd),
    .count_i   (s1_count_q),
    .drive_d_o (left_drive_d),
    .busy_d_o  (left_busy_d)
  );

  dsd_wheel #(
    .COUNT_BITS(COUNT_BITS)
  ) u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (right_cmd),
    .count_i   (s1_count_q),
    .drive_d_o (right_drive_d),
    .busy_d_o  (right_busy_d)
  );

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_width_q   <= PEN_UP_RESET;
      down_width_q <= PEN_DOWN_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_PEN_UP:   up_width_q   <= pwdata[WidthW-1:0];
        REG_PEN_DOWN: down_width_q <= pwdata[WidthW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PEN_UP:   prdata = {{(32-WidthW){1'b0}}, up_width_q};
      REG_PEN_DOWN: prdata = {{(32-WidthW){1'b0}}, down_width_q};
    endcase
  end

  // Pen and halt state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q     <= PEN_UP_RESET;
      stopped_q <= 1'b0;
    end else begin
      pen_q     <= pen_d;
      stopped_q <= stopped_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      left_q    <= left_drive_d;
      right_q   <= right_drive_d;
      pen_out_q <= pen_d;
      busy_q    <= left_busy_d || right_busy_d;
      halted_q  <= stopped_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_coils_o  = left_q;
  assign right_coils_o = right_q;
  assign pen_width_o   = pen_out_q;
  assign busy_res_o    = busy_q;
  assign halted_o      = halted_q;

  `DSD_ASSERT_NEXT(a_stop_is_sticky, stopped_q, stopped_q)
  `DSD_ASSERT_NEXT(a_pen_frozen_when_stopped, stopped_q, $stable(pen_q))
  `DSD_ASSERT_NEXT(a_stalled_request_kept, s1_valid_q && !advance, s1_valid_q && out_valid_q)

endmodule

[tb/sv/dual_stepper_half_step_driver_unit_tb.sv]
`timescale 1ns / 1ps

module dual_stepper_half_step_driver_unit_tb;
  import dsd_pkg::*;

  localparam int unsigned LoadBits = 16;
  localparam int MaxOwed = (1 << (LoadBits - 1)) - 1;
  localparam int MinOwed = -MaxOwed - 1;
  localparam int IdleLimit = 2000;
  localparam int RandomPerPhase = 400;
  localparam int HoldCycles = 60;

  // Coil bit touched by each new phase, two bits per phase, phase 0 in the low bits.
  localparam logic [15:0] RiseCoils = 16'hB61C;
  localparam logic [15:0] FallCoils = 16'h2D87;

  typedef struct packed {
    logic [CoilW-1:0]  left_coils;
    logic [CoilW-1:0]  right_coils;
    logic [WidthW-1:0] pen_width;
    logic              busy;
    logic              halted;
  } drive_state_t;

  typedef struct {
    op_e              op;
    logic [StepW-1:0] count;
    bit               fixed;
    drive_state_t     want;
  } script_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [2:0]        operation_i = OP_TICK;
  logic [StepW-1:0]  step_count_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CoilW-1:0]  left_coils_o;
  logic [CoilW-1:0]  right_coils_o;
  logic [WidthW-1:0] pen_width_o;
  logic              busy_res_o;
  logic              halted_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  dual_stepper_half_step_driver_unit #(
    .COUNT_BITS(LoadBits)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .step_count_i  (step_count_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_coils_o  (left_coils_o),
    .right_coils_o (right_coils_o),
    .pen_width_o   (pen_width_o),
    .busy_res_o    (busy_res_o),
    .halted_o      (halted_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the driver state.
  logic signed [LoadBits-1:0] steps_owed [2];
  logic [2:0]                 wheel_phase [2];
  logic [CoilW-1:0]           wheel_coils [2];
  logic [WidthW-1:0]          pen_now;
  logic [WidthW-1:0]          up_width;
  logic [WidthW-1:0]          down_width;
  bit                         is_halted;

  drive_state_t queued_drive_states [$];

  int failures = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int saturations = 0;
  int widths_written = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  function automatic logic signed [LoadBits-1:0] clamp_add(logic signed [LoadBits-1:0] a,
                                                           int delta);
    int s;
    s = int'(a) + delta;
    if (s > MaxOwed) begin
      s = MaxOwed;
      saturations++;
    end else if (s < MinOwed) begin
      s = MinOwed;
      saturations++;
    end
    return s[LoadBits-1:0];
  endfunction

  function automatic void advance_wheel(int w);
    int  coil_no;
    bit  rising;
    if (steps_owed[w] == 0) return;
    rising = (steps_owed[w] > 0);
    if (rising) begin
      wheel_phase[w] = wheel_phase[w] + 3'd1;
      steps_owed[w] = steps_owed[w] - 16'sd1;
      coil_no = int'(RiseCoils[2*wheel_phase[w] +: 2]);
    end else begin
      wheel_phase[w] = wheel_phase[w] - 3'd1;
      steps_owed[w] = steps_owed[w] + 16'sd1;
      coil_no = int'(FallCoils[2*wheel_phase[w] +: 2]);
    end
    // Even phases energize a coil, odd phases release one.
    wheel_coils[w][coil_no] = !wheel_phase[w][0];
  endfunction

  function automatic drive_state_t apply_request(op_e op, logic [StepW-1:0] n);
    int           amount;
    drive_state_t r;
    amount = int'(n);
    if (!is_halted) begin
      case (op)
        OP_TICK: begin
          advance_wheel(0);
          advance_wheel(1);
        end
        OP_FORWARD: begin
          steps_owed[0] = clamp_add(steps_owed[0], amount);
          steps_owed[1] = clamp_add(steps_owed[1], amount);
        end
        OP_BACKWARD: begin
          steps_owed[0] = clamp_add(steps_owed[0], -amount);
          steps_owed[1] = clamp_add(steps_owed[1], -amount);
        end
        OP_LEFT: begin
          steps_owed[0] = clamp_add(steps_owed[0], -amount);
          steps_owed[1] = clamp_add(steps_owed[1], amount);
        end
        OP_RIGHT: begin
          steps_owed[0] = clamp_add(steps_owed[0], amount);
          steps_owed[1] = clamp_add(steps_owed[1], -amount);
        end
        OP_PEN_UP: pen_now = up_width;
        OP_PEN_DOWN: pen_now = down_width;
        default: begin
          pen_now = up_width;
          is_halted = 1'b1;
        end
      endcase
    end
    r.left_coils = wheel_coils[0];
    r.right_coils = wheel_coils[1];
    r.pen_width = pen_now;
    r.busy = (steps_owed[0] != 0) || (steps_owed[1] != 0);
    r.halted = is_halted;
    return r;
  endfunction

  function automatic script_row_t row(op_e op, logic [StepW-1:0] count, bit fixed,
                                      drive_state_t want);
    script_row_t r;
    r.op = op;
    r.count = count;
    r.fixed = fixed;
    r.want = want;
    return r;
  endfunction

  function automatic void report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  task automatic send_request(op_e op, logic [StepW-1:0] n, bit fixed, drive_state_t want);
    drive_state_t predicted;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    step_count_i <= n;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = apply_request(op, n);
    queued_drive_states.push_back(fixed ? want : predicted);
    requests_sent++;
  endtask

  task automatic drain_results(int settle);
    in_valid_i <= 1'b0;
    while (queued_drive_states.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_width(logic sel, logic [31:0] value);
    logic [WidthW-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_PEN_UP) up_width = value[WidthW-1:0];
    else down_width = value[WidthW-1:0];
    want = value[WidthW-1:0];
    widths_written++;
    @(posedge clk_i);
    psel <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    report_field(sel == REG_PEN_UP ? "pen_up_width readback" : "pen_down_width readback",
                 32'(want), 32'(prdata[WidthW-1:0]));
  endtask

  // Result side: random stalls, plus a long hold-off whenever the request side asks.
  always @(posedge clk_i) begin
    if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      stall_left <= HoldCycles;
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_result
    drive_state_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (queued_drive_states.size() == 0) begin
        $display("%0t: result with nothing expected, got coils %0d/%0d pen %0d", $time,
                 left_coils_o, right_coils_o, pen_width_o);
        failures++;
      end else begin
        want = queued_drive_states.pop_front();
        report_field("left_coils", 32'(want.left_coils), 32'(left_coils_o));
        report_field("right_coils", 32'(want.right_coils), 32'(right_coils_o));
        report_field("pen_width", 32'(want.pen_width), 32'(pen_width_o));
        report_field("busy_res", 32'(want.busy), 32'(busy_res_o));
        report_field("halted", 32'(want.halted), 32'(halted_o));
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("dual_stepper_half_step_driver_unit verification failed");
      $finish;
    end
  end

  initial begin
    script_row_t      script [$];
    int               roll;
    op_e              op;
    logic [StepW-1:0] cnt;
    for (int w = 0; w < 2; w++) begin
      steps_owed[w] = '0;
      wheel_phase[w] = '0;
      wheel_coils[w] = '0;
    end
    up_width = PEN_UP_RESET;
    down_width = PEN_DOWN_RESET;
    pen_now = PEN_UP_RESET;
    is_halted = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Wheels are brought back to rest before the counters are driven to both limits.
    script.push_back(row(OP_TICK, 15'd0, 1'b1, {4'd0, 4'd0, 15'd700, 1'b0, 1'b0}));
    script.push_back(row(OP_PEN_DOWN, 15'd0, 1'b1, {4'd0, 4'd0, 15'd1200, 1'b0, 1'b0}));
    script.push_back(row(OP_PEN_UP, 15'h7FFF, 1'b1, {4'd0, 4'd0, 15'd700, 1'b0, 1'b0}));
    script.push_back(row(OP_FORWARD, 15'd0, 1'b1, {4'd0, 4'd0, 15'd700, 1'b0, 1'b0}));
    script.push_back(row(OP_FORWARD, 15'd1, 1'b1, {4'd0, 4'd0, 15'd700, 1'b1, 1'b0}));
    script.push_back(row(OP_TICK, 15'd0, 1'b0, '0));
    script.push_back(row(OP_RIGHT, 15'd3, 1'b0, '0));
    repeat (3) script.push_back(row(OP_TICK, 15'd0, 1'b0, '0));
    script.push_back(row(OP_LEFT, 15'd2, 1'b0, '0));
    repeat (2) script.push_back(row(OP_TICK, 15'h7FFF, 1'b0, '0));
    script.push_back(row(OP_BACKWARD, 15'd1, 1'b0, '0));
    script.push_back(row(OP_TICK, 15'd0, 1'b0, '0));
    repeat (2) script.push_back(row(OP_FORWARD, 15'h7FFF, 1'b0, '0));
    repeat (3) script.push_back(row(OP_BACKWARD, 15'h7FFF, 1'b0, '0));
    script.push_back(row(OP_FORWARD, 15'h7FFF, 1'b0, '0));
    script.push_back(row(OP_FORWARD, 15'd1, 1'b0, '0));

    foreach (script[i]) send_request(script[i].op, script[i].count, script[i].fixed,
                                     script[i].want);

    for (int phase_no = 0; phase_no < 3; phase_no++) begin
      drain_results(4);
      case (phase_no)
        0: begin
          sender_idle_pct = 24;
          receiver_idle_pct = 86;
          write_width(REG_PEN_UP, 32'd0);
          write_width(REG_PEN_DOWN, 32'd20000);
        end
        1: begin
          sender_idle_pct = 86;
          receiver_idle_pct = 24;
          write_width(REG_PEN_UP, {16'($urandom_range(0, 16'hFFFF)), 16'd20000});
          write_width(REG_PEN_DOWN, 32'd0);
        end
        default: begin
          sender_idle_pct = 0;
          receiver_idle_pct = 0;
          write_width(REG_PEN_UP, $urandom_range(0, 20000));
          write_width(REG_PEN_DOWN, 32'h7FFF);
        end
      endcase
      @(posedge clk_i);
      for (int i = 0; i < RandomPerPhase; i++) begin
        if (phase_no == 2 && i == 100) hold_asked++;
        if (phase_no == 2 && i == 250) drain_results(0);
        roll = $urandom_range(0, 99);
        cnt = StepW'($urandom_range(0, 16'h7FFF));
        if (roll < 50) begin
          send_request(OP_TICK, cnt, 1'b0, '0);
        end else if (roll < 80) begin
          send_request(op_e'($urandom_range(OP_FORWARD, OP_RIGHT)),
                       StepW'($urandom_range(0, 12)), 1'b0, '0);
        end else if (roll < 85) begin
          // A long move followed by its reverse keeps the wheels near rest.
          op = op_e'($urandom_range(OP_FORWARD, OP_RIGHT));
          send_request(op, cnt, 1'b0, '0);
          op = (op == OP_FORWARD) ? OP_BACKWARD : (op == OP_BACKWARD) ? OP_FORWARD :
               (op == OP_LEFT) ? OP_RIGHT : OP_LEFT;
          send_request(op, cnt, 1'b0, '0);
        end else begin
          send_request(roll[0] ? OP_PEN_UP : OP_PEN_DOWN, cnt, 1'b0, '0);
        end
      end
    end

    // The end request halts the driver for good, so it closes the run.
    drain_results(4);
    send_request(OP_END, StepW'($urandom_range(0, 16'h7FFF)), 1'b0, '0);
    send_request(OP_TICK, 15'd0, 1'b0, '0);
    send_request(OP_FORWARD, 15'd9, 1'b0, '0);
    send_request(OP_PEN_DOWN, 15'd0, 1'b0, '0);
    send_request(OP_LEFT, 15'h7FFF, 1'b0, '0);
    send_request(OP_TICK, 15'h7FFF, 1'b0, '0);
    send_request(OP_END, 15'd0, 1'b0, '0);
    drain_results(8);

    $display("Ran %0d requests: directed rows, three stall patterns, a long output hold-off",
             requests_sent);
    $display("and the final halt; %0d results checked, %0d saturations, %0d width writes.",
             results_checked, saturations, widths_written);
    if (failures == 0) begin
      $display("dual_stepper_half_step_driver_unit verification clean");
    end else begin
      $display("dual_stepper_half_step_driver_unit verification failed");
    end
    $finish;
  end

endmodule
